>>> src/lgr_pkg.sv
// Package for the local geocentric rotation block: widths, payload types,
// configuration register indexes and the matrix entry rounding function.
// No dependencies; every other file in src uses it by scoped names.
package lgr_pkg;

  localparam int FRAC = 16;                  // fraction bits of the trig registers
  localparam int CW   = 32;                  // component width
  localparam int RW   = FRAC + 2;            // register width, signed Q1.16
  localparam int PW   = 2 * RW;              // product of two registers
  localparam int EW   = RW + 2;              // matrix entry width
  localparam int MW   = EW + CW;             // entry times component
  localparam int SW   = MW + 2;              // sum of three products
  localparam int TW   = SW - FRAC;           // sum after the shift

  typedef logic signed [CW-1:0] comp_t;
  typedef logic signed [RW-1:0] reg_t;
  typedef logic signed [EW-1:0] ent_t;
  typedef logic signed [TW-1:0] acc_t;

  typedef comp_t [2:0]      comp_vec_t;
  typedef ent_t  [2:0][2:0] mat_t;
  typedef acc_t  [2:0]      acc_vec_t;

  typedef enum logic [1:0] {
    CFG_SIN_LAT = 2'd0,
    CFG_COS_LAT = 2'd1,
    CFG_SIN_LON = 2'd2,
    CFG_COS_LON = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    reg_t sin_lat;
    reg_t cos_lat;
    reg_t sin_lon;
    reg_t cos_lon;
  } cfg_t;

  typedef struct packed {
    logic  mode;
    comp_t comp_a;
    comp_t comp_b;
    comp_t comp_c;
  } in_t;

  typedef struct packed {
    comp_t out_a;
    comp_t out_b;
    comp_t out_c;
    logic  saturated;
  } out_t;

  // Word leaving the matrix stages: one row per output, one column per component.
  typedef struct packed {
    mat_t      mat;
    comp_vec_t comp;
  } mat_item_t;

  localparam reg_t ONE_Q = reg_t'(1) << FRAC;
  localparam cfg_t CFG_RESET = '{sin_lat: '0, cos_lat: ONE_Q, sin_lon: '0, cos_lon: ONE_Q};

  localparam logic [SW-1:0] SUM_ROUND = SW'(1) << (FRAC - 1);
  localparam logic [PW:0]   ENT_ROUND = (PW + 1)'(1) << (FRAC - 1);
  localparam logic [CW-1:0] COMP_MAX  = {1'b0, {(CW - 1){1'b1}}};
  localparam logic [CW-1:0] COMP_MIN  = {1'b1, {(CW - 1){1'b0}}};

  // Sign-extends a register to entry width.
  function automatic ent_t ext_reg(input reg_t v);
    return {{(EW - RW){v[RW-1]}}, v};
  endfunction

  // Rounds a register product half up to Q.FRAC, negating it first if asked.
  function automatic ent_t round_entry(input logic signed [PW-1:0] p, input logic neg);
    logic signed [PW:0] w;
    logic signed [PW:0] s;
    w = {p[PW-1], p};
    if (neg) begin
      w = -w;
    end
    s = w + ENT_ROUND;
    return EW'(s >>> FRAC);
  endfunction

endpackage

>>> src/lgr_matrix.sv
// Matrix build stages: register products of the trig registers, then the
// rounded rotation matrix, transposed for the inverse mode. Uses lgr_pkg.
module lgr_matrix (
  input  logic               clk,
  input  logic               rst_n,
  input  lgr_pkg::cfg_t      cfg,
  input  logic               in_valid,
  output logic               in_ready,
  input  lgr_pkg::in_t       in_data,
  output logic               mat_valid,
  input  logic               mat_ready,
  output lgr_pkg::mat_item_t mat_data
);

  logic v1_r, v2_r;
  logic rdy1, rdy2;

  lgr_pkg::in_t               item_r;
  logic signed [lgr_pkg::PW-1:0] p_sbcl_r, p_cbcl_r, p_sbsl_r, p_cbsl_r;
  lgr_pkg::mat_t              rot;
  lgr_pkg::mat_item_t         mat_nxt, mat_r;

  assign rdy2      = !v2_r || mat_ready;
  assign rdy1      = !v1_r || rdy2;
  assign in_ready  = rdy1;
  assign mat_valid = v2_r;
  assign mat_data  = mat_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      if (rdy1) begin
        v1_r <= in_valid;
      end
      if (rdy2) begin
        v2_r <= v1_r;
      end
    end
  end

  // The forward matrix, built from the register products and the trig registers.
  always_comb begin
    rot[0][0] = lgr_pkg::round_entry(p_sbcl_r, 1'b1);
    rot[0][1] = -lgr_pkg::ext_reg(cfg.sin_lon);
    rot[0][2] = lgr_pkg::round_entry(p_cbcl_r, 1'b0);
    rot[1][0] = lgr_pkg::round_entry(p_sbsl_r, 1'b1);
    rot[1][1] = lgr_pkg::ext_reg(cfg.cos_lon);
    rot[1][2] = lgr_pkg::round_entry(p_cbsl_r, 1'b0);
    rot[2][0] = lgr_pkg::ext_reg(cfg.cos_lat);
    rot[2][1] = '0;
    rot[2][2] = lgr_pkg::ext_reg(cfg.sin_lat);
    for (int i = 0; i < 3; i++) begin
      for (int j = 0; j < 3; j++) begin
        mat_nxt.mat[i][j] = item_r.mode ? rot[j][i] : rot[i][j];
      end
    end
    mat_nxt.comp[0] = item_r.comp_a;
    mat_nxt.comp[1] = item_r.comp_b;
    mat_nxt.comp[2] = item_r.comp_c;
  end

  always_ff @(posedge clk) begin
    if (in_valid && rdy1) begin
      item_r   <= in_data;
      p_sbcl_r <= $signed(cfg.sin_lat) * $signed(cfg.cos_lon);
      p_cbcl_r <= $signed(cfg.cos_lat) * $signed(cfg.cos_lon);
      p_sbsl_r <= $signed(cfg.sin_lat) * $signed(cfg.sin_lon);
      p_cbsl_r <= $signed(cfg.cos_lat) * $signed(cfg.sin_lon);
    end
    if (v1_r && rdy2) begin
      mat_r <= mat_nxt;
    end
  end

endmodule

>>> src/lgr_dot.sv
// Dot product stages: nine entry-by-component products, then three rounded
// and shifted sums. Uses lgr_pkg.
module lgr_dot (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               mat_valid,
  output logic               mat_ready,
  input  lgr_pkg::mat_item_t mat_data,
  output logic               sum_valid,
  input  logic               sum_ready,
  output lgr_pkg::acc_vec_t  sum_data
);

  logic v3_r, v4_r;
  logic rdy3, rdy4;

  logic signed [lgr_pkg::MW-1:0] prod_r [3][3];
  logic signed [lgr_pkg::SW-1:0] acc [3];
  lgr_pkg::acc_vec_t             sum_nxt, sum_r;

  assign rdy4      = !v4_r || sum_ready;
  assign rdy3      = !v3_r || rdy4;
  assign mat_ready = rdy3;
  assign sum_valid = v4_r;
  assign sum_data  = sum_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (rdy3) begin
        v3_r <= mat_valid;
      end
      if (rdy4) begin
        v4_r <= v3_r;
      end
    end
  end

  // Round half up, then an arithmetic shift by the fraction width.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      acc[i] = lgr_pkg::SW'(prod_r[i][0]) + lgr_pkg::SW'(prod_r[i][1])
             + lgr_pkg::SW'(prod_r[i][2]) + lgr_pkg::SUM_ROUND;
      sum_nxt[i] = lgr_pkg::TW'(acc[i] >>> lgr_pkg::FRAC);
    end
  end

  always_ff @(posedge clk) begin
    if (mat_valid && rdy3) begin
      for (int i = 0; i < 3; i++) begin
        for (int j = 0; j < 3; j++) begin
          prod_r[i][j] <= $signed(mat_data.mat[i][j]) * $signed(mat_data.comp[j]);
        end
      end
    end
    if (v3_r && rdy4) begin
      sum_r <= sum_nxt;
    end
  end

endmodule

>>> src/lgr_sat.sv
// Output stage: clips each shifted sum to the component range, sets the
// saturation flag and holds the result word. Uses lgr_pkg.
module lgr_sat (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              sum_valid,
  output logic              sum_ready,
  input  lgr_pkg::acc_vec_t sum_data,
  output logic              out_valid,
  input  logic              out_ready,
  output lgr_pkg::out_t     out_data
);

  logic                      v5_r;
  logic                      rdy5;
  logic [2:0]                ovf;
  logic [lgr_pkg::CW-1:0]    clip [3];
  lgr_pkg::out_t             out_nxt, out_r;

  assign rdy5      = !v5_r || out_ready;
  assign sum_ready = rdy5;
  assign out_valid = v5_r;
  assign out_data  = out_r;

  // A sum fits when every bit above the component's sign bit copies the sign.
  always_comb begin
    for (int i = 0; i < 3; i++) begin
      ovf[i]  = sum_data[i][lgr_pkg::TW-1:lgr_pkg::CW-1]
                != {(lgr_pkg::TW - lgr_pkg::CW + 1){sum_data[i][lgr_pkg::TW-1]}};
      clip[i] = ovf[i] ? (sum_data[i][lgr_pkg::TW-1] ? lgr_pkg::COMP_MIN : lgr_pkg::COMP_MAX)
                       : sum_data[i][lgr_pkg::CW-1:0];
    end
    out_nxt.out_a     = clip[0];
    out_nxt.out_b     = clip[1];
    out_nxt.out_c     = clip[2];
    out_nxt.saturated = |ovf;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v5_r <= 1'b0;
    end else if (rdy5) begin
      v5_r <= sum_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (sum_valid && rdy5) begin
      out_r <= out_nxt;
    end
  end

endmodule

>>> src/local_geocentric_rotation.sv
// An accepted input word is loaded into the first of five register stages
// and is in the fifth when it shows on out_valid/out_data. Throughput:
// one word per cycle while out_ready stays high, since each stage then
// takes a word per cycle. Reset (rst_n, synchronous, active low) empties
// the pipeline and loads the trig registers with latitude and longitude zero.
module local_geocentric_rotation (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      in_valid,
  output logic                      in_ready,
  input  lgr_pkg::in_t              in_data,
  output logic                      out_valid,
  input  logic                      out_ready,
  output lgr_pkg::out_t             out_data,
  input  logic                      cfg_we,
  input  lgr_pkg::cfg_idx_t         cfg_index,
  input  logic [lgr_pkg::RW-1:0]    cfg_wdata
);

  // The sines and cosines of latitude and longitude, signed Q1.16. The user
  // must change them only while the pipeline is empty; the block does not check.
  lgr_pkg::cfg_t cfg_r;

  logic               mat_valid, mat_ready;
  lgr_pkg::mat_item_t mat_data;
  logic               sum_valid, sum_ready;
  lgr_pkg::acc_vec_t  sum_data;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r <= lgr_pkg::CFG_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        lgr_pkg::CFG_SIN_LAT: cfg_r.sin_lat <= cfg_wdata;
        lgr_pkg::CFG_COS_LAT: cfg_r.cos_lat <= cfg_wdata;
        lgr_pkg::CFG_SIN_LON: cfg_r.sin_lon <= cfg_wdata;
        lgr_pkg::CFG_COS_LON: cfg_r.cos_lon <= cfg_wdata;
      endcase
    end
  end

  // Stages one and two: the register products, then the rounded matrix
  // entries. In the inverse mode the matrix is transposed here, so the
  // later stages do the same work for both directions.
  lgr_matrix u_matrix (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .mat_valid (mat_valid),
    .mat_ready (mat_ready),
    .mat_data  (mat_data)
  );

  // Stages three and four: nine 20 by 32 bit products, then the three
  // row sums, rounded half up and shifted down by the fraction width.
  lgr_dot u_dot (
    .clk       (clk),
    .rst_n     (rst_n),
    .mat_valid (mat_valid),
    .mat_ready (mat_ready),
    .mat_data  (mat_data),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum_data  (sum_data)
  );

  // Stage five: saturation and the output register. Each stage takes a new
  // word whenever it is empty or the stage after it moves, so bubbles close
  // up and a waiting result stalls only the stages behind it.
  lgr_sat u_sat (
    .clk       (clk),
    .rst_n     (rst_n),
    .sum_valid (sum_valid),
    .sum_ready (sum_ready),
    .sum_data  (sum_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  // The input side can only be held off by a result that waits downstream.
  a_stall_source: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ready |-> (out_valid && !out_ready))
    else $error("input stalled without back-pressure at the output");

  // A clipped word carries at least one component at a range limit.
  a_sat_limit: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_data.saturated) |->
      (out_data.out_a == lgr_pkg::COMP_MAX || out_data.out_a == lgr_pkg::COMP_MIN ||
       out_data.out_b == lgr_pkg::COMP_MAX || out_data.out_b == lgr_pkg::COMP_MIN ||
       out_data.out_c == lgr_pkg::COMP_MAX || out_data.out_c == lgr_pkg::COMP_MIN))
    else $error("saturation flag set with no component at a limit");

  // Reset empties the pipeline, so no result shows right after it.
  a_reset_empty: assert property (@(posedge clk)
    $past(!rst_n) |-> !out_valid)
    else $error("result word valid right after reset");

endmodule

>>> tb/sv/tb_local_geocentric_rotation.sv
// Self-checking testbench for local_geocentric_rotation: NEU/XYZ rotation of
// input words under several trig register settings, checked against a predictor.
// Depends on lgr_pkg (src/lgr_pkg.sv) and the local_geocentric_rotation RTL.
module tb_local_geocentric_rotation;
  timeunit 1ns;
  timeprecision 1ps;

  import lgr_pkg::*;

  // The block has five register stages, and the settle wait adds a margin.
  localparam int PIPE_DEPTH = 5;
  localparam int SETTLE     = PIPE_DEPTH + 3;

  localparam longint COMP_HI = (longint'(1) <<< (CW - 1)) - 1;
  localparam longint COMP_LO = -(longint'(1) <<< (CW - 1));

  localparam comp_t C_MAX = comp_t'(COMP_HI);
  localparam comp_t C_MIN = comp_t'(COMP_LO);

  // Q1.16 values for the trig registers, plus the ends of the 18-bit field.
  localparam reg_t TRIG_ONE     = reg_t'(65536);
  localparam reg_t TRIG_NEG_ONE = reg_t'(-65536);
  localparam reg_t TRIG_TOP     = reg_t'(131071);
  localparam reg_t TRIG_BOTTOM  = reg_t'(-131072);

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_ready;
  in_t       in_data;
  logic      out_valid;
  logic      out_ready;
  out_t      out_data;
  logic      cfg_we;
  cfg_idx_t  cfg_index;
  logic [RW-1:0] cfg_wdata;

  local_geocentric_rotation u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata)
  );

  // Predictor copy of the trig registers, loaded with the reset orientation
  // (latitude and longitude zero) and updated on every configuration write.
  reg_t lat_sin = '0;
  reg_t lat_cos = TRIG_ONE;
  reg_t lon_sin = '0;
  reg_t lon_cos = TRIG_ONE;

  // Rotated vectors still owed by the block, oldest first.
  out_t rotated_due[$];

  int   err_count   = 0;
  int   words_out   = 0;
  bit   steady_flow = 1'b0;   // when set, neither side idles
  int   hold_left   = 0;

  initial clk = 1'b0;
  always #6 clk = ~clk;

  // Runaway guard: far beyond the slowest legal run of the whole stimulus.
  initial begin
    #10_000_000;
    $display("tb_local_geocentric_rotation: errors");
    $finish;
  end

  task automatic flag_error(input string what);
    err_count++;
    $display("MISMATCH @%0t: %s", $realtime, what);
  endtask

  // Round half up from Q.32 (product of two Q.16 values) down to Q.16.
  function automatic longint round_q(input longint p);
    return (p + (longint'(1) <<< (FRAC - 1))) >>> FRAC;
  endfunction

  // Expected result for one input word under the current trig registers.
  // The matrix is built exactly as the rotation defines it, even when the
  // sines and cosines are not a true rotation or exceed 1.0.
  function automatic out_t rotate_vector(input in_t w);
    longint m [3][3];
    longint v [3];
    comp_t  res [3];
    longint sb, cb, sl, cl;
    longint acc, s;
    bit     clipped;
    out_t   r;
    sb = longint'(lat_sin);
    cb = longint'(lat_cos);
    sl = longint'(lon_sin);
    cl = longint'(lon_cos);
    m[0][0] = round_q(-(sb * cl));
    m[0][1] = -sl;
    m[0][2] = round_q(cb * cl);
    m[1][0] = round_q(-(sb * sl));
    m[1][1] = cl;
    m[1][2] = round_q(cb * sl);
    m[2][0] = cb;
    m[2][1] = 0;
    m[2][2] = sb;
    v[0] = longint'(w.comp_a);
    v[1] = longint'(w.comp_b);
    v[2] = longint'(w.comp_c);
    clipped = 1'b0;
    for (int i = 0; i < 3; i++) begin
      acc = 0;
      // Mode 1 walks the transpose, which is the inverse for a true rotation.
      for (int j = 0; j < 3; j++) begin
        acc += (w.mode ? m[j][i] : m[i][j]) * v[j];
      end
      s = round_q(acc);
      if (s > COMP_HI) begin
        s = COMP_HI;
        clipped = 1'b1;
      end else if (s < COMP_LO) begin
        s = COMP_LO;
        clipped = 1'b1;
      end
      res[i] = comp_t'(s);
    end
    r.out_a     = res[0];
    r.out_b     = res[1];
    r.out_c     = res[2];
    r.saturated = clipped;
    return r;
  endfunction

  function automatic in_t make_word(input bit mode, input comp_t a, input comp_t b,
                                    input comp_t c);
    in_t w;
    w.mode   = mode;
    w.comp_a = a;
    w.comp_b = b;
    w.comp_c = c;
    return w;
  endfunction

  // Idle length for either side: mostly none, sometimes short, rarely long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (steady_flow || r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 30);
  endfunction

  // Sends one word. Called at a falling edge and returns at a falling edge.
  // Valid stays high across back-to-back words; it drops only for a gap.
  task automatic send_word(input in_t w);
    int gap;
    gap = idle_len();
    if (gap > 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid = 1'b1;
    in_data  = w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    rotated_due.push_back(rotate_vector(w));
    @(negedge clk);
  endtask

  // Stops sending and waits until every owed result has come back, so the
  // pipeline is empty and the trig registers may be rewritten.
  task automatic drain_pipeline();
    in_valid = 1'b0;
    while (rotated_due.size() > 0) @(posedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_trig(input cfg_idx_t idx, input reg_t val);
    cfg_we    = 1'b1;
    cfg_index = idx;
    cfg_wdata = val;
    @(posedge clk);
    case (idx)
      CFG_SIN_LAT: lat_sin = val;
      CFG_COS_LAT: lat_cos = val;
      CFG_SIN_LON: lon_sin = val;
      CFG_COS_LON: lon_cos = val;
      default: ;
    endcase
    @(negedge clk);
    cfg_we = 1'b0;
  endtask

  task automatic set_orientation(input reg_t sb, input reg_t cb, input reg_t sl,
                                 input reg_t cl);
    drain_pipeline();
    write_trig(CFG_SIN_LAT, sb);
    write_trig(CFG_COS_LAT, cb);
    write_trig(CFG_SIN_LON, sl);
    write_trig(CFG_COS_LON, cl);
  endtask

  // The reset registers give a pure axis swap: north goes to Z, up goes to X.
  task automatic test_reset_orientation();
    send_word(make_word(1'b0, C_MAX, C_MIN, 32'sd0));
    send_word(make_word(1'b1, C_MIN, C_MAX, -32'sd1));
    send_word(make_word(1'b0, -32'sd1, 32'sd1, C_MIN));
  endtask

  // Full-scale components against unit and negative unit entries, including
  // all trig registers at one, which is no rotation at all; sums clip both ways.
  task automatic test_full_scale();
    set_orientation(TRIG_ONE, TRIG_ONE, TRIG_ONE, TRIG_ONE);
    send_word(make_word(1'b0, C_MAX, C_MAX, C_MAX));
    send_word(make_word(1'b1, C_MIN, C_MIN, C_MIN));
    send_word(make_word(1'b0, 32'sd1, -32'sd1, 32'sd0));
    set_orientation(TRIG_NEG_ONE, TRIG_NEG_ONE, TRIG_NEG_ONE, TRIG_NEG_ONE);
    send_word(make_word(1'b0, C_MAX, C_MIN, C_MAX));
    send_word(make_word(1'b1, C_MIN, C_MAX, C_MIN));
  endtask

  // Registers written past 1.0 are used as they are, at the ends of the field.
  task automatic test_oversized_registers();
    set_orientation(TRIG_TOP, TRIG_BOTTOM, TRIG_TOP, TRIG_BOTTOM);
    send_word(make_word(1'b0, C_MAX, C_MAX, C_MIN));
    send_word(make_word(1'b1, 32'sd12345, -32'sd54321, 32'sd7));
    send_word(make_word(1'b1, C_MIN, C_MAX, C_MAX));
  endtask

  // Half-way cases of both roundings. With only sin_lat nonzero at one LSB,
  // the Z output is c / 65536 rounded half up; the second setting puts an
  // exact half into the product entries.
  task automatic test_rounding_ties();
    set_orientation(reg_t'(1), '0, '0, '0);
    send_word(make_word(1'b0, 32'sd0, 32'sd0, 32'sd32768));
    send_word(make_word(1'b0, 32'sd0, 32'sd0, -32'sd32768));
    send_word(make_word(1'b1, 32'sd0, 32'sd0, 32'sd32767));
    send_word(make_word(1'b1, 32'sd0, 32'sd0, -32'sd32769));
    set_orientation(reg_t'(1), reg_t'(1), reg_t'(32768), reg_t'(32768));
    send_word(make_word(1'b0, 32'sd65536, 32'sd1, 32'sd65536));
    send_word(make_word(1'b1, 32'sd65536, -32'sd1, -32'sd65536));
  endtask

  function automatic comp_t rand_comp();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return comp_t'($urandom);
      4, 5:       return comp_t'(int'($urandom_range(0, 2000)) - 1000);
      6:          return comp_t'(COMP_HI - longint'($urandom_range(0, 3)));
      7:          return comp_t'(COMP_LO + longint'($urandom_range(0, 3)));
      default:    return comp_t'($signed($urandom) >>> $urandom_range(1, 30));
    endcase
  endfunction

  function automatic in_t rand_word();
    return make_word(1'($urandom), rand_comp(), rand_comp(), rand_comp());
  endfunction

  // Trig value: a plausible Q1.16 value, a special value (one, minus one, zero
  // or a field extreme), or any 18-bit pattern at all.
  function automatic reg_t rand_trig();
    case ($urandom_range(0, 5))
      0, 1, 2: return reg_t'(int'($urandom_range(0, 131072)) - 65536);
      3: begin
        case ($urandom_range(0, 4))
          0:       return TRIG_ONE;
          1:       return TRIG_NEG_ONE;
          2:       return TRIG_TOP;
          3:       return TRIG_BOTTOM;
          default: return '0;
        endcase
      end
      default: return reg_t'($urandom);
    endcase
  endfunction

  // Full rate in both directions: one word per cycle in and out.
  task automatic test_back_to_back();
    set_orientation(reg_t'(46341), reg_t'(46341), reg_t'(-23170), reg_t'(60547));
    steady_flow = 1'b1;
    repeat (100) send_word(rand_word());
    steady_flow = 1'b0;
  endtask

  // Random words under a fresh random orientation per frame. Every frame
  // starts by waiting for the pipeline to empty before the new writes.
  task automatic test_random_frames(input int frames, input int per_frame);
    for (int f = 0; f < frames; f++) begin
      set_orientation(rand_trig(), rand_trig(), rand_trig(), rand_trig());
      repeat (per_frame) send_word(rand_word());
    end
  endtask

  // Result receiver: random stalls, mostly short, now and then long.
  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (!rst_n || steady_flow) begin
        out_ready = !steady_flow ? 1'b0 : 1'b1;
        hold_left = 0;
      end else if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = 1'b1;
        if ($urandom_range(0, 3) == 0) hold_left = idle_len();
      end
    end
  end

  // Every result word is matched against the oldest owed rotation.
  always @(posedge clk) begin : check_results
    out_t want;
    if (rst_n && out_valid && out_ready) begin
      if (rotated_due.size() == 0) begin
        flag_error($sformatf("result word %0d arrived with nothing owed", words_out));
      end else begin
        want = rotated_due.pop_front();
        if (out_data.out_a !== want.out_a)
          flag_error($sformatf("word %0d out_a got %0d want %0d",
                               words_out, out_data.out_a, want.out_a));
        if (out_data.out_b !== want.out_b)
          flag_error($sformatf("word %0d out_b got %0d want %0d",
                               words_out, out_data.out_b, want.out_b));
        if (out_data.out_c !== want.out_c)
          flag_error($sformatf("word %0d out_c got %0d want %0d",
                               words_out, out_data.out_c, want.out_c));
        if (out_data.saturated !== want.saturated)
          flag_error($sformatf("word %0d saturated got %0b want %0b",
                               words_out, out_data.saturated, want.saturated));
      end
      words_out++;
    end
  end

  initial begin
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    cfg_we    = 1'b0;
    cfg_index = CFG_SIN_LAT;
    cfg_wdata = '0;
    repeat (5) @(negedge clk);
    rst_n = 1'b1;

    test_reset_orientation();
    test_full_scale();
    test_oversized_registers();
    test_rounding_ties();
    test_back_to_back();
    test_random_frames(19, 100);

    // Let the last words come out, then watch a while for strays.
    drain_pipeline();
    repeat (4 * PIPE_DEPTH) @(posedge clk);
    if (err_count == 0) begin
      $display("tb_local_geocentric_rotation: clean");
    end else begin
      $display("tb_local_geocentric_rotation: errors");
    end
    $finish;
  end

endmodule

>>> sim.f
src/lgr_pkg.sv
src/lgr_matrix.sv
src/lgr_dot.sv
src/lgr_sat.sv
src/local_geocentric_rotation.sv
tb/sv/tb_local_geocentric_rotation.sv
